### hw/rtl/address_translation_session_table_unit_assert.svh
// ---------------------------------------------------------------------------
// Session table assertion macros
// Shorthand for clocked assertions with asynchronous reset disable.
// ---------------------------------------------------------------------------
`ifndef ADDRESS_TRANSLATION_SESSION_TABLE_UNIT_ASSERT_SVH
`define ADDRESS_TRANSLATION_SESSION_TABLE_UNIT_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define ATST_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define ATST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/atst_pkg.sv
// ---------------------------------------------------------------------------
// Session table package
// Shared constants, opcodes, controller states and control/status types.
// ---------------------------------------------------------------------------
package atst_pkg;

	localparam int SLOTS_DEF = 16;

	localparam int ADDR_W  = 32;
	localparam int PORT_W  = 16;
	localparam int TIME_W  = 32;
	localparam int SLOT_W  = 8;
	localparam int ENTRY_W = ADDR_W + PORT_W + TIME_W;

	localparam logic [ADDR_W-1:0] LOOPBACK_BASE = 32'h7F00_0000;
	localparam logic [23:0]       LOOPBACK_NET  = 24'h7F_0000;
	localparam logic [SLOT_W-1:0] LOOPBACK_OFS  = 8'd2;

	typedef enum logic [1:0] {
		OP_CREATE     = 2'd0,
		OP_LOOKUP_IN  = 2'd1,
		OP_LOOKUP_OUT = 2'd2,
		OP_NONE       = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic write;
		logic fin;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic scan_hit;
		logic scan_end;
		logic is_create;
		logic out_busy;
	} sts_t;

endpackage

### hw/rtl/atst_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module atst_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/atst_ctrl.sv
// ---------------------------------------------------------------------------
// Session table controller
// Sequences accept, table scan, write-back and result hand-off.
// ---------------------------------------------------------------------------
`include "address_translation_session_table_unit_assert.svh"

module atst_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    command,
	output atst_pkg::ctl_t ctl,
	input  atst_pkg::sts_t sts
);

	import atst_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					// unused opcode: skip the scan, report no match
					state_d  = (op_t'(command) == OP_NONE) ? ST_OUT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				ctl.scan = 1'b1;
				if (sts.scan_hit || sts.scan_end) begin
					state_d = sts.is_create ? ST_WRITE : ST_OUT;
				end
			end
			ST_WRITE: begin
				ctl.write = 1'b1;
				state_d   = ST_OUT;
			end
			ST_OUT: begin
				if (!sts.out_busy) begin
					ctl.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`ATST_ASSERT_NEXT(a_create_writes, (state_q == ST_SCAN) && sts.is_create && (sts.scan_hit || sts.scan_end), state_q == ST_WRITE, "create scan did not reach write-back")
	`ATST_ASSERT_SAME(a_hit_end_excl, state_q == ST_SCAN, !(sts.scan_hit && sts.scan_end), "scan hit and scan end together")
	`ATST_ASSERT_NEXT(a_fin_to_idle, ctl.fin, state_q == ST_IDLE, "result hand-off did not return to idle")

endmodule

### hw/rtl/atst_dp.sv
// ---------------------------------------------------------------------------
// Session table datapath
// Holds the table RAM, valid bits, scan pointer, compare and result words.
// ---------------------------------------------------------------------------
`include "address_translation_session_table_unit_assert.svh"

module atst_dp #(
	parameter int SLOTS = atst_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  atst_pkg::ctl_t                ctl,
	output atst_pkg::sts_t                sts,
	input  logic [1:0]                    command,
	input  logic [atst_pkg::ADDR_W-1:0]   addr,
	input  logic [atst_pkg::PORT_W-1:0]   port,
	input  logic [atst_pkg::TIME_W-1:0]   now,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic [atst_pkg::SLOT_W-1:0]   slot,
	output logic [atst_pkg::ADDR_W-1:0]   external_addr,
	output logic [atst_pkg::PORT_W-1:0]   external_port,
	output logic [atst_pkg::ADDR_W-1:0]   loopback_addr
);

	import atst_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [SLOT_W-1:0] TGT_MAX = SLOT_W'(SLOTS + 1);

	// captured word
	op_t               op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [PORT_W-1:0] port_q;
	logic [TIME_W-1:0] now_q;
	logic              tgt_ok_q;
	logic [IDX_W-1:0]  tgt_idx_q;

	// scan pipeline
	logic [CNT_W-1:0]  iss_cnt_q;
	logic              issue_en;
	logic              cmp_vld_s1;
	logic [IDX_W-1:0]  cmp_idx_s1;
	logic              ent_vld_s1;
	logic [SLOTS-1:0]  valid_q;
	logic [ENTRY_W-1:0] rdata;
	logic [ENTRY_W-1:0] entry;
	logic [ADDR_W-1:0] e_addr;
	logic [PORT_W-1:0] e_port;
	logic [TIME_W-1:0] e_time;
	logic              cmp_act;
	logic              hit_c;
	logic              last_c;
	logic              best_upd;

	// oldest-slot tracker and chosen slot
	logic [TIME_W-1:0] best_time_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [IDX_W-1:0]  pick_idx_q;

	// pending result
	logic              res_found_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [PORT_W-1:0] res_port_q;
	logic [SLOT_W-1:0] res_slot;

	// output register
	logic              out_valid_q;
	logic              out_found_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [PORT_W-1:0] out_port_q;
	logic [ADDR_W-1:0] out_loop_q;

	assign issue_en = ctl.scan && (iss_cnt_q < CNT_W'(SLOTS));

	atst_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOTS),
		.ADDR_W(IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (ctl.write),
		.waddr(pick_idx_q),
		.wdata({addr_q, port_q, now_q}),
		.raddr(iss_cnt_q[IDX_W-1:0]),
		.rdata(rdata)
	);

	// never-written entries read as zero
	assign entry  = ent_vld_s1 ? rdata : '0;
	assign e_addr = entry[ENTRY_W-1 -: ADDR_W];
	assign e_port = entry[TIME_W +: PORT_W];
	assign e_time = entry[TIME_W-1:0];

	assign cmp_act  = ctl.scan && cmp_vld_s1;
	assign last_c   = (cmp_idx_s1 == IDX_W'(SLOTS - 1));
	assign best_upd = (best_time_q == '0) || (e_time < best_time_q);

	always_comb begin
		case (op_q)
			OP_CREATE:     hit_c = (e_time == '0);
			OP_LOOKUP_IN:  hit_c = (e_addr == addr_q) && (e_port == port_q);
			OP_LOOKUP_OUT: hit_c = tgt_ok_q && (cmp_idx_s1 == tgt_idx_q);
			default:       hit_c = 1'b0;
		endcase
	end

	assign sts.scan_hit  = cmp_act && hit_c;
	assign sts.scan_end  = cmp_act && last_c && !hit_c;
	assign sts.is_create = (op_q == OP_CREATE);
	assign sts.out_busy  = out_valid_q && !out_ready;

	assign res_slot = SLOT_W'(res_idx_q);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_cnt_q   <= '0;
			cmp_vld_s1  <= 1'b0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				iss_cnt_q <= '0;
			end else if (issue_en) begin
				iss_cnt_q <= iss_cnt_q + CNT_W'(1);
			end
			cmp_vld_s1 <= issue_en;
			if (ctl.write) begin
				valid_q[pick_idx_q] <= 1'b1;
			end
			if (ctl.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= iss_cnt_q[IDX_W-1:0];
		ent_vld_s1 <= valid_q[iss_cnt_q[IDX_W-1:0]];

		if (ctl.load) begin
			op_q        <= op_t'(command);
			addr_q      <= addr;
			port_q      <= port;
			now_q       <= now;
			tgt_ok_q    <= (addr[ADDR_W-1:8] == LOOPBACK_NET) &&
				(addr[7:0] >= LOOPBACK_OFS) && (addr[7:0] <= TGT_MAX);
			tgt_idx_q   <= IDX_W'(addr[7:0] - LOOPBACK_OFS);
			best_time_q <= '0;
			best_idx_q  <= '0;
			pick_idx_q  <= '0;
			res_found_q <= 1'b0;
			res_idx_q   <= '0;
			res_addr_q  <= '0;
			res_port_q  <= '0;
		end

		// track the oldest stamp, first index wins ties
		if (cmp_act && sts.is_create && !hit_c && best_upd) begin
			best_time_q <= e_time;
			best_idx_q  <= cmp_idx_s1;
		end

		if (sts.scan_hit) begin
			pick_idx_q <= cmp_idx_s1;
			if (!sts.is_create) begin
				res_found_q <= 1'b1;
				res_idx_q   <= cmp_idx_s1;
				res_addr_q  <= e_addr;
				res_port_q  <= e_port;
			end
		end else if (sts.scan_end) begin
			pick_idx_q <= best_upd ? cmp_idx_s1 : best_idx_q;
		end

		if (ctl.write) begin
			res_found_q <= 1'b1;
			res_idx_q   <= pick_idx_q;
			res_addr_q  <= addr_q;
			res_port_q  <= port_q;
		end

		if (ctl.fin) begin
			out_found_q <= res_found_q;
			out_slot_q  <= res_slot;
			out_addr_q  <= res_addr_q;
			out_port_q  <= res_port_q;
			out_loop_q  <= res_found_q ?
				(LOOPBACK_BASE | ADDR_W'(res_slot + LOOPBACK_OFS)) : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = out_found_q;
	assign slot          = out_slot_q;
	assign external_addr = out_addr_q;
	assign external_port = out_port_q;
	assign loopback_addr = out_loop_q;

	`ATST_ASSERT_SAME(a_out_from_fin, $rose(out_valid_q), $past(ctl.fin), "result word appeared without hand-off")
	`ATST_ASSERT_NEXT(a_write_found, ctl.write, res_found_q, "create result not marked found")
	`ATST_ASSERT_SAME(a_pick_range, ctl.write, pick_idx_q <= IDX_W'(SLOTS - 1), "write slot out of range")

endmodule

### hw/rtl/address_translation_session_table_unit.sv
// ---------------------------------------------------------------------------
// Address translation session table
// Fixed table of sessions mapping external endpoints to 127.0.0.(slot+2).
// ---------------------------------------------------------------------------
//
//   channel   handshake              word
//   --------  ---------------------  ------------------------------------------
//   in        in_valid / in_ready    command, addr, port, now
//   out       out_valid / out_ready  found, slot, external_addr,
//                                    external_port, loopback_addr
//
// Flow: one word at a time. A create or lookup walks the table RAM one
//   entry per cycle through its single read port; a word passes through
//   accept, the SLOTS reads and their registered compare, write-back for a
//   create, and the hand-off to the output register before the next accept.
//   A hit ends the walk early. The unused opcode skips the walk and goes
//   straight to the hand-off.
// Reset: per-entry valid bits clear at once; an entry never written reads
//   as zero, so no clearing pass runs after reset.
// Stalls: the output register holds a finished result while the next word
//   is accepted and walked; only the final hand-off waits on out_ready.
//
module address_translation_session_table_unit #(
	parameter int SLOTS = atst_pkg::SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  command,
	input  logic [atst_pkg::ADDR_W-1:0] addr,
	input  logic [atst_pkg::PORT_W-1:0] port,
	input  logic [atst_pkg::TIME_W-1:0] now,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        found,
	output logic [atst_pkg::SLOT_W-1:0] slot,
	output logic [atst_pkg::ADDR_W-1:0] external_addr,
	output logic [atst_pkg::PORT_W-1:0] external_port,
	output logic [atst_pkg::ADDR_W-1:0] loopback_addr
);

	import atst_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// sequencing: idle, walk, write-back, hand-off
	atst_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command (command),
		.ctl     (ctl),
		.sts     (sts)
	);

	// table storage, compare and result words
	atst_dp #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.command      (command),
		.addr         (addr),
		.port         (port),
		.now          (now),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.slot         (slot),
		.external_addr(external_addr),
		.external_port(external_port),
		.loopback_addr(loopback_addr)
	);

endmodule
